>>> sv/emx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// emx_pkg
// Types, constants and arithmetic step functions shared by the two-voice
// mixer: sample widths, square root and division step records.
// ----------------------------------------------------------------------------
package emx_pkg;

  localparam int SAMPLE_BITS = 8;
  localparam int SQ_BITS     = 2 * SAMPLE_BITS - 1;   // square of a magnitude <= 2^14
  localparam int RAD_BITS    = 2 * SAMPLE_BITS + 2;   // doubled energy, even bit count
  localparam int ROOT_BITS   = SAMPLE_BITS + 1;       // root <= 2^SAMPLE_BITS
  localparam int SREM_BITS   = ROOT_BITS + 1;         // root remainder <= 2*root
  localparam int QUO_BITS    = SAMPLE_BITS;           // voice magnitude
  localparam int DREM_BITS   = ROOT_BITS;             // division remainder < divisor

  localparam int NUM_STAGES     = 8;
  localparam int SQRT_STAGES    = 3;
  localparam int SQRT_PER_STAGE = ROOT_BITS / SQRT_STAGES;
  localparam int DIV_PER_STAGE  = QUO_BITS / 2;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MID  = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
  localparam logic [ROOT_BITS-1:0]   LOW_DIVISOR = ROOT_BITS'(127);
  localparam logic [RAD_BITS-1:0]    LOW_ENERGY  = RAD_BITS'(127);

  // Digit-by-digit square root state
  typedef struct packed {
    logic [RAD_BITS-1:0]  rad;   // radicand, consumed two bits per step from the top
    logic [SREM_BITS-1:0] rem;
    logic [ROOT_BITS-1:0] root;
  } sqrt_t;

  // Restoring division state
  typedef struct packed {
    logic [DREM_BITS-1:0]  rem;
    logic [QUO_BITS-1:0]   dvd;  // dividend bits still to bring down
    logic [QUO_BITS-1:0]   quo;
  } div_t;

  // One pipeline register's payload
  typedef struct packed {
    logic                   neg_a;
    logic                   neg_b;
    logic [SQ_BITS-1:0]     sq_a;
    logic [SQ_BITS-1:0]     sq_b;
    logic [SAMPLE_BITS-1:0] right;
    logic                   low;
    sqrt_t                  sq;
    logic [ROOT_BITS-1:0]   divisor;
    div_t                   da;
    div_t                   db;
    logic [SAMPLE_BITS-1:0] mixed;
  } stage_t;

  // One root bit: bring down two radicand bits, try 4*root+1
  function automatic sqrt_t sqrt_step(sqrt_t s);
    sqrt_t                r;
    logic [SREM_BITS+1:0] rem2;
    logic [SREM_BITS+1:0] trial;
    rem2  = {s.rem, s.rad[RAD_BITS-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    r.rad = {s.rad[RAD_BITS-3:0], 2'b00};
    if (rem2 >= trial) begin
      r.rem  = SREM_BITS'(rem2 - trial);
      r.root = {s.root[ROOT_BITS-2:0], 1'b1};
    end else begin
      r.rem  = rem2[SREM_BITS-1:0];
      r.root = {s.root[ROOT_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

  // One quotient bit of a restoring division
  function automatic div_t div_step(div_t s, logic [ROOT_BITS-1:0] d);
    div_t                 r;
    logic [DREM_BITS:0]   t;
    t     = {s.rem, s.dvd[QUO_BITS-1]};
    r.dvd = {s.dvd[QUO_BITS-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      r.rem = DREM_BITS'(t - {1'b0, d});
      r.quo = {s.quo[QUO_BITS-2:0], 1'b1};
    end else begin
      r.rem = t[DREM_BITS-1:0];
      r.quo = {s.quo[QUO_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/emx_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// emx_in_if
// Input channel: one pair of unsigned voice samples per transfer.
// ----------------------------------------------------------------------------
interface emx_in_if;
  logic                            valid;
  logic                            ready;
  logic [emx_pkg::SAMPLE_BITS-1:0] first_sample;
  logic [emx_pkg::SAMPLE_BITS-1:0] second_sample;

  modport source (output valid, output first_sample, output second_sample, input ready);
  modport sink   (input valid, input first_sample, input second_sample, output ready);
endinterface
`default_nettype wire

>>> sv/emx_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// emx_out_if
// Result channel: mixed left sample and right pass-through per transfer.
// ----------------------------------------------------------------------------
interface emx_out_if;
  logic                            valid;
  logic                            ready;
  logic [emx_pkg::SAMPLE_BITS-1:0] mixed_left;
  logic [emx_pkg::SAMPLE_BITS-1:0] right_passthrough;

  modport source (output valid, output mixed_left, output right_passthrough, input ready);
  modport sink   (input valid, input mixed_left, input right_passthrough, output ready);
endinterface
`default_nettype wire

>>> sv/energy_normalized_two_voice_mixer.sv
`default_nettype none
// The pipeline has eight register stages from input transfer to result transfer.
// Throughput: one sample pair per cycle unless the output blocks; stages are squares,
//   energy, three square-root stages (3 root bits each), two divider stages (4 bits each), mix.
// Each stage holds its item only while the stage after it is full and blocked.
// Reset (synchronous, active low) clears the stage valid bits; data is not reset.
// ----------------------------------------------------------------------------
// energy_normalized_two_voice_mixer
// Mixes two 8-bit voices, each scaled by A^2/sqrt(2(A^2+B^2)) (by A^2/127 when that
// doubled energy is below 127), and passes the second voice through as the right channel.
// ----------------------------------------------------------------------------
module energy_normalized_two_voice_mixer (
  input  wire logic clk,
  input  wire logic rst_n,
  emx_in_if.sink    in_chan,
  emx_out_if.source out_chan
);
  import emx_pkg::*;

  stage_t                  pipe_r   [NUM_STAGES];
  stage_t                  pipe_nxt [NUM_STAGES];
  logic [NUM_STAGES-1:0]   valid_r;
  logic [NUM_STAGES-1:0]   valid_in;   // valid offered to each stage
  logic [NUM_STAGES:0]     stage_rdy;  // stage k may load this cycle

  // Ready chain: a stage loads when empty or when its content moves on
  always_comb begin
    stage_rdy[NUM_STAGES] = out_chan.ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      stage_rdy[k] = !valid_r[k] || stage_rdy[k+1];
    end
    valid_in = {valid_r[NUM_STAGES-2:0], in_chan.valid};
  end

  // Stage 0: recentre and square
  always_comb begin
    logic [SAMPLE_BITS-1:0] ma;
    logic [SAMPLE_BITS-1:0] mb;
    logic [2*SAMPLE_BITS-1:0] pa;
    logic [2*SAMPLE_BITS-1:0] pb;
    pipe_nxt[0] = pipe_r[0];
    if (in_chan.first_sample < SAMPLE_MID) begin
      ma = SAMPLE_MID - in_chan.first_sample;
    end else begin
      ma = in_chan.first_sample - SAMPLE_MID;
    end
    if (in_chan.second_sample < SAMPLE_MID) begin
      mb = SAMPLE_MID - in_chan.second_sample;
    end else begin
      mb = in_chan.second_sample - SAMPLE_MID;
    end
    pa = (2*SAMPLE_BITS)'(ma) * (2*SAMPLE_BITS)'(ma);
    pb = (2*SAMPLE_BITS)'(mb) * (2*SAMPLE_BITS)'(mb);
    pipe_nxt[0].neg_a = in_chan.first_sample < SAMPLE_MID;
    pipe_nxt[0].neg_b = in_chan.second_sample < SAMPLE_MID;
    pipe_nxt[0].sq_a  = pa[SQ_BITS-1:0];
    pipe_nxt[0].sq_b  = pb[SQ_BITS-1:0];
    pipe_nxt[0].right = in_chan.second_sample;
  end

  // Stage 1: doubled energy and low-energy flag
  always_comb begin
    logic [RAD_BITS-1:0] energy;
    pipe_nxt[1] = pipe_r[0];
    energy = {RAD_BITS'({1'b0, pipe_r[0].sq_a} + {1'b0, pipe_r[0].sq_b})} << 1;
    pipe_nxt[1].low     = energy < LOW_ENERGY;
    pipe_nxt[1].sq.rad  = energy;
    pipe_nxt[1].sq.rem  = '0;
    pipe_nxt[1].sq.root = '0;
  end

  // Stages 2..4: square root, three root bits per stage
  for (genvar k = 2; k < 2 + SQRT_STAGES; k++) begin : g_sqrt
    always_comb begin
      pipe_nxt[k] = pipe_r[k-1];
      for (int i = 0; i < SQRT_PER_STAGE; i++) begin
        pipe_nxt[k].sq = sqrt_step(pipe_nxt[k].sq);
      end
    end
  end

  // Stage 5: pick divisor, first half of both divisions
  always_comb begin
    stage_t s;
    s = pipe_r[4];
    s.divisor = s.low ? LOW_DIVISOR : s.sq.root;
    // quotient fits 8 bits, so the top dividend bits start as remainder
    s.da.rem  = DREM_BITS'(s.sq_a[SQ_BITS-1:QUO_BITS]);
    s.da.dvd  = s.sq_a[QUO_BITS-1:0];
    s.da.quo  = '0;
    s.db.rem  = DREM_BITS'(s.sq_b[SQ_BITS-1:QUO_BITS]);
    s.db.dvd  = s.sq_b[QUO_BITS-1:0];
    s.db.quo  = '0;
    for (int i = 0; i < DIV_PER_STAGE; i++) begin
      s.da = div_step(s.da, s.divisor);
      s.db = div_step(s.db, s.divisor);
    end
    pipe_nxt[5] = s;
  end

  // Stage 6: second half of both divisions
  always_comb begin
    pipe_nxt[6] = pipe_r[5];
    for (int i = 0; i < DIV_PER_STAGE; i++) begin
      pipe_nxt[6].da = div_step(pipe_nxt[6].da, pipe_r[5].divisor);
      pipe_nxt[6].db = div_step(pipe_nxt[6].db, pipe_r[5].divisor);
    end
  end

  // Stage 7: signed mix around mid-scale, modulo 2^8
  always_comb begin
    logic [SAMPLE_BITS-1:0] m;
    pipe_nxt[7] = pipe_r[6];
    m = pipe_r[6].neg_a ? SAMPLE_MID - pipe_r[6].da.quo : SAMPLE_MID + pipe_r[6].da.quo;
    m = pipe_r[6].neg_b ? m - pipe_r[6].db.quo : m + pipe_r[6].db.quo;
    pipe_nxt[7].mixed = m;
  end

  // Pipeline registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (stage_rdy[k] && valid_in[k]) begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (stage_rdy[k]) begin
          valid_r[k] <= valid_in[k];
        end
      end
    end
  end

  assign in_chan.ready              = stage_rdy[0];
  assign out_chan.valid             = valid_r[NUM_STAGES-1];
  assign out_chan.mixed_left        = pipe_r[NUM_STAGES-1].mixed;
  assign out_chan.right_passthrough = pipe_r[NUM_STAGES-1].right;

`ifndef SYNTHESIS
  // Input blocks only when every stage holds an item
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> &valid_r)
    else $error("input stalled with an empty stage");

  // Root after the last square-root stage never exceeds full scale
  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[4] |-> pipe_r[4].sq.root <= ROOT_BITS'(1 << SAMPLE_BITS))
    else $error("square root out of range");

  // Divisor is never below eleven
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[5] |-> pipe_r[5].divisor >= ROOT_BITS'(11))
    else $error("divisor too small");

  // A blocked result stays in place
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[NUM_STAGES-1] && !out_chan.ready |=> $stable(pipe_r[NUM_STAGES-1]))
    else $error("blocked result changed");
`endif

endmodule
`default_nettype wire

>>> bench/emx_mix_checker.sv
// ----------------------------------------------------------------------------
// emx_mix_checker
// Watches both channels of the two-voice mixer. Every input transfer gets its
// expected mixed/right pair computed and queued; every result transfer is
// compared field by field against the oldest queued pair.
// ----------------------------------------------------------------------------
module emx_mix_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [emx_pkg::SAMPLE_BITS-1:0] in_first_sample,
  input  logic [emx_pkg::SAMPLE_BITS-1:0] in_second_sample,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [emx_pkg::SAMPLE_BITS-1:0] out_mixed_left,
  input  logic [emx_pkg::SAMPLE_BITS-1:0] out_right_passthrough,
  output int                              fail_count,
  output int                              pending
);

  localparam int SB = emx_pkg::SAMPLE_BITS;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [SB-1:0] mixed_left;
    logic [SB-1:0] right;
  } mix_pair_t;

  mix_pair_t mix_expect_q[$];

  // Energy-normalized mix of one sample pair
  function automatic logic [SB-1:0] predict_mix(input logic [SB-1:0] a,
                                                input logic [SB-1:0] b);
    logic [SB:0]       mag_a;
    logic [SB:0]       mag_b;
    logic [2*SB:0]     sq_a;
    logic [2*SB:0]     sq_b;
    logic [2*SB+1:0]   energy;
    logic [SB:0]       root;
    logic [SB:0]       trial;
    logic [2*SB:0]     divisor;
    logic [2*SB:0]     va;
    logic [2*SB:0]     vb;
    logic [SB+1:0]     mix;
    int                i;
    mag_a = (SB+1)'((a < emx_pkg::SAMPLE_MID) ? emx_pkg::SAMPLE_MID - a
                                                : a - emx_pkg::SAMPLE_MID);
    mag_b = (SB+1)'((b < emx_pkg::SAMPLE_MID) ? emx_pkg::SAMPLE_MID - b
                                                : b - emx_pkg::SAMPLE_MID);
    sq_a  = (2*SB+1)'(mag_a) * (2*SB+1)'(mag_a);
    sq_b  = (2*SB+1)'(mag_b) * (2*SB+1)'(mag_b);
    // doubled energy kept wide enough that the all-zero pair does not wrap
    energy = {(sq_a + sq_b), 1'b0};
    // floor square root, one bit at a time from the top
    root = '0;
    for (i = SB; i >= 0; i--) begin
      trial = root | ((SB+1)'(1) << i);
      if ((2*SB+2)'(trial) * (2*SB+2)'(trial) <= energy) root = trial;
    end
    // quiet pairs use a fixed divisor
    divisor = (energy < (2*SB+2)'(127)) ? (2*SB+1)'(127) : (2*SB+1)'(root);
    va  = sq_a / divisor;
    vb  = sq_b / divisor;
    mix = (SB+2)'(emx_pkg::SAMPLE_MID);
    mix = (a < emx_pkg::SAMPLE_MID) ? mix - (SB+2)'(va) : mix + (SB+2)'(va);
    mix = (b < emx_pkg::SAMPLE_MID) ? mix - (SB+2)'(vb) : mix + (SB+2)'(vb);
    return mix[SB-1:0];
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Compare result transfers first, then queue the new input transfer
  always @(posedge clk) begin
    mix_pair_t exp_pair;
    mix_pair_t new_pair;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (mix_expect_q.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("unexpected result: mixed_left %0d right_passthrough %0d",
                     out_mixed_left, out_right_passthrough);
          fail_count <= fail_count + 1;
        end else begin
          exp_pair = mix_expect_q.pop_front();
          if (exp_pair.mixed_left !== out_mixed_left ||
              exp_pair.right !== out_right_passthrough) begin
            if (fail_count < MAX_REPORTS)
              $display("mismatch: mixed_left exp %0d got %0d, right_passthrough exp %0d got %0d",
                       exp_pair.mixed_left, out_mixed_left,
                       exp_pair.right, out_right_passthrough);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        new_pair.mixed_left = predict_mix(in_first_sample, in_second_sample);
        new_pair.right      = in_second_sample;
        mix_expect_q.push_back(new_pair);
      end
      pending <= mix_expect_q.size();
    end
  end

endmodule

>>> bench/energy_normalized_two_voice_mixer_tb.sv
// ----------------------------------------------------------------------------
// energy_normalized_two_voice_mixer_tb
// Drives sample pairs into the mixer under varying idle patterns on both
// sides, with a long receiver hold-off and a full drain, and reports the
// verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module energy_normalized_two_voice_mixer_tb;

  localparam int SB            = emx_pkg::SAMPLE_BITS;
  localparam int HOLD_CYCLES   = 64;
  localparam int STALL_LIMIT   = 2000;
  localparam int TAIL_CYCLES   = 16;
  localparam int RANDOM_ITEMS  = 476;

  logic clk = 1'b0;
  logic rst_n;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  int fail_count;
  int pending;

  emx_in_if  in_chan();
  emx_out_if out_chan();

  energy_normalized_two_voice_mixer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  emx_mix_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_chan.valid),
    .in_ready              (in_chan.ready),
    .in_first_sample       (in_chan.first_sample),
    .in_second_sample      (in_chan.second_sample),
    .out_valid             (out_chan.valid),
    .out_ready             (out_chan.ready),
    .out_mixed_left        (out_chan.mixed_left),
    .out_right_passthrough (out_chan.right_passthrough),
    .fail_count            (fail_count),
    .pending               (pending)
  );

  // 8-unit clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offer one pair, with random idle cycles ahead of it; valid stays high after
  task automatic send_pair(input logic [SB-1:0] a, input logic [SB-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.first_sample  <= a;
    in_chan.second_sample <= b;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Stop offering and wait until every queued result has come back
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One random sample: mostly uniform, some near silence, some corner values
  function automatic logic [SB-1:0] pick_sample();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) return SB'($urandom_range(255));
    if (sel < 8) return SB'(128 + $urandom_range(16) - 8);
    case ($urandom_range(6))
      0: return SB'(0);
      1: return SB'(1);
      2: return SB'(127);
      3: return SB'(128);
      4: return SB'(129);
      5: return SB'(254);
      default: return SB'(255);
    endcase
  endfunction

  task automatic send_random(input int count, input bit with_hold);
    int i;
    for (i = 0; i < count; i++) begin
      if (with_hold && i == count / 2) hold_requests <= hold_requests + 1;
      send_pair(pick_sample(), pick_sample());
    end
  endtask

  // Receiver: random ready, with a long hold-off on request
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (holds_done != hold_requests) begin
        holds_done = holds_done + 1;
        hold_left  = HOLD_CYCLES - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
    end
    $display("energy_normalized_two_voice_mixer_tb NOT OK");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.first_sample  = '0;
    in_chan.second_sample = '0;
    send_idle_pct         = 38;
    recv_idle_pct         = 70;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: silence, full scale, mixed signs, low-energy boundary
    send_pair(8'd128, 8'd128);
    send_pair(8'd0,   8'd0);
    send_pair(8'd255, 8'd255);
    send_pair(8'd0,   8'd255);
    send_pair(8'd255, 8'd0);
    send_pair(8'd128, 8'd0);
    send_pair(8'd0,   8'd128);
    send_pair(8'd255, 8'd128);
    send_pair(8'd128, 8'd255);
    send_pair(8'd127, 8'd127);
    send_pair(8'd129, 8'd129);
    send_pair(8'd127, 8'd128);
    send_pair(8'd128, 8'd129);
    send_pair(8'd133, 8'd133);
    send_pair(8'd134, 8'd133);
    send_pair(8'd123, 8'd122);
    send_pair(8'd134, 8'd134);
    send_pair(8'd136, 8'd128);
    send_pair(8'd120, 8'd128);
    send_pair(8'd1,   8'd254);
    send_pair(8'd254, 8'd1);
    send_pair(8'd64,  8'd192);
    send_pair(8'd192, 8'd64);
    send_pair(8'd200, 8'd50);
    send_pair(8'd170, 8'd85);

    send_random(RANDOM_ITEMS, 1'b1);
    drain_results();

    send_idle_pct <= 70;
    recv_idle_pct <= 38;
    send_random(RANDOM_ITEMS, 1'b0);

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    send_random(RANDOM_ITEMS, 1'b1);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("energy_normalized_two_voice_mixer_tb OK");
    else
      $display("energy_normalized_two_voice_mixer_tb NOT OK");
    $finish;
  end

endmodule
